// ===== src/line_pixel_stepper_unit_assert.svh =====
// Assertion macros shared by the line pixel stepper modules.
`ifndef LINE_PIXEL_STEPPER_UNIT_ASSERT_SVH
`define LINE_PIXEL_STEPPER_UNIT_ASSERT_SVH

// Same-cycle implication, checked on clk_i, off while rst_ni is low.
`define LPS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk_i, off while rst_ni is low.
`define LPS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/lps_pkg.sv =====
// Shared types, constants and helpers of the line pixel stepper.
package lps_pkg;

  // Item operation carried in tuser
  typedef enum logic {
    OP_START   = 1'b0,
    OP_ADVANCE = 1'b1
  } op_e;

  localparam int unsigned WIDTH_W       = 11;
  localparam int unsigned BPP_LOG2_W    = 2;
  localparam int unsigned COLOR_W       = 8;
  localparam int unsigned WORD_INDEX_W  = 20;
  localparam int unsigned BIT_SHIFT_W   = 5;
  localparam int unsigned CFG_INDEX_W   = 1;
  localparam int unsigned CFG_DATA_W    = 11;

  // Register indexes of the config port
  localparam logic [CFG_INDEX_W-1:0] REG_SCREEN_WIDTH = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_BPP_LOG2     = 1'b1;

  localparam logic [WIDTH_W-1:0]    SCREEN_WIDTH_RST = 11'd800;
  localparam logic [BPP_LOG2_W-1:0] BPP_LOG2_RST     = 2'd0;

  // log2 of the bits in one frame buffer word
  localparam logic [2:0] WORD_BITS_LOG2 = 3'd5;

  typedef struct packed {
    logic [WIDTH_W-1:0]    screen_width;
    logic [BPP_LOG2_W-1:0] bpp_log2;
  } cfg_t;

  // Mask that keeps the low 2^bpp_log2 bits of a color
  function automatic logic [COLOR_W-1:0] color_mask(input logic [BPP_LOG2_W-1:0] bpp_log2);
    logic [COLOR_W-1:0] mask;
    case (bpp_log2)
      2'd0:    mask = 8'h01;
      2'd1:    mask = 8'h03;
      2'd2:    mask = 8'h0F;
      default: mask = 8'hFF;
    endcase
    return mask;
  endfunction

endpackage

// ===== src/lps_stepper.sv =====
// Line state and error-term stepping, with one registered pixel stage.
`include "line_pixel_stepper_unit_assert.svh"

module lps_stepper import lps_pkg::*; #(
  parameter int unsigned COORD_BITS = 10
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // incoming items
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  op_e                   op_i,
  input  logic [COORD_BITS-1:0] start_x_i,
  input  logic [COORD_BITS-1:0] start_y_i,
  input  logic [COORD_BITS-1:0] end_x_i,
  input  logic [COORD_BITS-1:0] end_y_i,
  input  logic [COLOR_W-1:0]    color_i,
  // pixel toward the address stage
  output logic                  pix_valid_o,
  input  logic                  pix_ready_i,
  output logic [COORD_BITS-1:0] pix_x_o,
  output logic [COORD_BITS-1:0] pix_y_o,
  output logic [COLOR_W-1:0]    pix_color_o,
  output logic                  pix_last_o
);

  localparam int unsigned ERR_W = COORD_BITS + 2;

  // line state
  logic [COORD_BITS-1:0]   cur_x_q, cur_x_d, cur_y_q, cur_y_d;
  logic [COORD_BITS-1:0]   tgt_x_q, tgt_x_d, tgt_y_q, tgt_y_d;
  logic [COORD_BITS-1:0]   dx_q, dx_d, dy_q, dy_d;
  logic                    neg_x_q, neg_x_d, neg_y_q, neg_y_d;
  logic signed [ERR_W-1:0] err_q, err_d;
  logic [COLOR_W-1:0]      color_q, color_d;
  logic                    active_q, active_d;

  // pixel stage
  logic                    s1_valid_q, s1_valid_d;
  logic [COORD_BITS-1:0]   s1_x_q, s1_y_q;
  logic [COLOR_W-1:0]      s1_color_q;
  logic                    s1_last_q;

  logic                    accept, emit, is_start, new_last;
  logic [COORD_BITS-1:0]   dx_start, dy_start;
  logic signed [ERR_W-1:0] dx_s, dy_s;
  logic                    step_x, step_y;

  // handshake: stage frees when its pixel moves on
  assign in_ready_o = !s1_valid_q || pix_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign is_start   = (op_i == OP_START);
  assign emit       = is_start || active_q;

  assign dx_start = (end_x_i > start_x_i) ? end_x_i - start_x_i : start_x_i - end_x_i;
  assign dy_start = (end_y_i > start_y_i) ? end_y_i - start_y_i : start_y_i - end_y_i;

  // error-term decisions against the stored deltas
  assign dx_s   = $signed({2'b00, dx_q});
  assign dy_s   = $signed({2'b00, dy_q});
  assign step_x = err_q > -dx_s;
  assign step_y = err_q < dy_s;

  // next line state for a start or an advance
  always_comb begin
    cur_x_d = cur_x_q;
    cur_y_d = cur_y_q;
    tgt_x_d = tgt_x_q;
    tgt_y_d = tgt_y_q;
    dx_d    = dx_q;
    dy_d    = dy_q;
    neg_x_d = neg_x_q;
    neg_y_d = neg_y_q;
    err_d   = err_q;
    color_d = color_q;
    if (is_start) begin
      cur_x_d = start_x_i;
      cur_y_d = start_y_i;
      tgt_x_d = end_x_i;
      tgt_y_d = end_y_i;
      dx_d    = dx_start;
      dy_d    = dy_start;
      neg_x_d = !(start_x_i < end_x_i);
      neg_y_d = !(start_y_i < end_y_i);
      color_d = color_i;
      if (dx_start > dy_start) begin
        err_d = $signed({2'b00, dx_start >> 1});
      end else begin
        err_d = -$signed({2'b00, dy_start >> 1});
      end
    end else begin
      if (step_x) begin
        cur_x_d = neg_x_q ? cur_x_q - 1'b1 : cur_x_q + 1'b1;
      end
      if (step_y) begin
        cur_y_d = neg_y_q ? cur_y_q - 1'b1 : cur_y_q + 1'b1;
      end
      err_d = err_q - (step_x ? dy_s : '0) + (step_y ? dx_s : '0);
    end
  end

  assign new_last = (cur_x_d == tgt_x_d) && (cur_y_d == tgt_y_d);
  assign active_d = !new_last;

  assign s1_valid_d = accept ? emit : (s1_valid_q && !pix_ready_i);

  // line state registers: idle advances leave them untouched
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_x_q  <= '0;
      cur_y_q  <= '0;
      tgt_x_q  <= '0;
      tgt_y_q  <= '0;
      dx_q     <= '0;
      dy_q     <= '0;
      neg_x_q  <= 1'b0;
      neg_y_q  <= 1'b0;
      err_q    <= '0;
      color_q  <= '0;
      active_q <= 1'b0;
    end else if (accept && emit) begin
      cur_x_q  <= cur_x_d;
      cur_y_q  <= cur_y_d;
      tgt_x_q  <= tgt_x_d;
      tgt_y_q  <= tgt_y_d;
      dx_q     <= dx_d;
      dy_q     <= dy_d;
      neg_x_q  <= neg_x_d;
      neg_y_q  <= neg_y_d;
      err_q    <= err_d;
      color_q  <= color_d;
      active_q <= active_d;
    end
  end

  // pixel stage valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  // pixel stage payload
  always_ff @(posedge clk_i) begin
    if (accept && emit) begin
      s1_x_q     <= cur_x_d;
      s1_y_q     <= cur_y_d;
      s1_color_q <= color_d;
      s1_last_q  <= new_last;
    end
  end

  assign pix_valid_o = s1_valid_q;
  assign pix_x_o     = s1_x_q;
  assign pix_y_o     = s1_y_q;
  assign pix_color_o = s1_color_q;
  assign pix_last_o  = s1_last_q;

  `LPS_ASSERT_NEXT(a_idle_advance_silent, accept && !is_start && !active_q, !s1_valid_q,
    "advance with no line in progress produced a pixel")
  `LPS_ASSERT_NEXT(a_start_emits, accept && is_start, s1_valid_q && (s1_last_q == !active_q),
    "start item did not produce its first pixel")
  `LPS_ASSERT_NOW(a_last_ends_line, s1_valid_q && s1_last_q, !active_q,
    "line still active while its endpoint pixel is pending")

endmodule

// ===== src/lps_addr.sv =====
// Frame buffer addressing of a pixel and the output register.
`include "line_pixel_stepper_unit_assert.svh"

module lps_addr import lps_pkg::*; #(
  parameter int unsigned COORD_BITS = 10
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  cfg_t                    cfg_i,
  // pixel from the stepper
  input  logic                    pix_valid_i,
  output logic                    pix_ready_o,
  input  logic [COORD_BITS-1:0]   pix_x_i,
  input  logic [COORD_BITS-1:0]   pix_y_i,
  input  logic [COLOR_W-1:0]      pix_color_i,
  input  logic                    pix_last_i,
  // result item
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [COORD_BITS-1:0]   out_x_o,
  output logic [COORD_BITS-1:0]   out_y_o,
  output logic [WORD_INDEX_W-1:0] out_word_index_o,
  output logic [BIT_SHIFT_W-1:0]  out_bit_shift_o,
  output logic [COLOR_W-1:0]      out_value_o,
  output logic                    out_last_o
);

  localparam int unsigned PROD_W = COORD_BITS + WIDTH_W;
  localparam int unsigned PIX_W  = PROD_W + 1;
  localparam int unsigned EXT_W  = PIX_W + WORD_INDEX_W;

  logic                    out_valid_q, out_valid_d;
  logic [COORD_BITS-1:0]   x_q, y_q;
  logic [WORD_INDEX_W-1:0] word_q;
  logic [BIT_SHIFT_W-1:0]  shift_q;
  logic [COLOR_W-1:0]      value_q;
  logic                    last_q;

  logic                    load;
  logic [PROD_W-1:0]       prod;
  logic [PIX_W-1:0]        pix_num;
  logic [EXT_W-1:0]        pix_ext;
  logic [EXT_W-1:0]        pix_words;
  logic [2:0]              word_shift;
  logic [BIT_SHIFT_W-1:0]  pix_low;
  logic [BIT_SHIFT_W-1:0]  bit_shift;

  assign pix_ready_o = !out_valid_q || out_ready_i;
  assign load        = pix_valid_i && pix_ready_o;

  // linear pixel number x + y * width, split into word and bit position
  assign prod       = PROD_W'(pix_y_i) * PROD_W'(cfg_i.screen_width);
  assign pix_num    = PIX_W'(prod) + PIX_W'(pix_x_i);
  assign pix_ext    = EXT_W'(pix_num);
  assign word_shift = WORD_BITS_LOG2 - {1'b0, cfg_i.bpp_log2};
  assign pix_words  = pix_ext >> word_shift;
  assign pix_low    = pix_num[BIT_SHIFT_W-1:0];
  assign bit_shift  = pix_low << cfg_i.bpp_log2;

  assign out_valid_d = load || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      x_q     <= pix_x_i;
      y_q     <= pix_y_i;
      word_q  <= pix_words[WORD_INDEX_W-1:0];
      shift_q <= bit_shift;
      value_q <= pix_color_i & color_mask(cfg_i.bpp_log2);
      last_q  <= pix_last_i;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign out_x_o          = x_q;
  assign out_y_o          = y_q;
  assign out_word_index_o = word_q;
  assign out_bit_shift_o  = shift_q;
  assign out_value_o      = value_q;
  assign out_last_o       = last_q;

  `LPS_ASSERT_NEXT(a_load_shows, load, out_valid_q,
    "pixel taken from the stepper did not reach the output register")
  `LPS_ASSERT_NEXT(a_stall_holds, out_valid_q && !out_ready_i, out_valid_q,
    "stalled result item dropped")
  `LPS_ASSERT_NOW(a_shift_aligned, out_valid_q,
    (shift_q & ((BIT_SHIFT_W'(1) << cfg_i.bpp_log2) - BIT_SHIFT_W'(1))) == '0,
    "bit shift not aligned to the pixel size")

endmodule

// ===== src/line_pixel_stepper_unit.sv =====
// Top level of the line pixel stepper: ports, config registers, field packing.
//
//   channel  direction  handshake                    payload
//   s_axis   in         s_axis_tvalid/s_axis_tready  tuser: operation; tdata: endpoints, color
//   m_axis   out        m_axis_tvalid/m_axis_tready  tdata: pixel, location, value; tlast
//   cfg      in         cfg_valid_i/cfg_ready_o      cfg_index_i, cfg_data_i
//
// One item per cycle sustained while the output is not stalled; a pixel is
// registered first in the stepper's pixel register, then in the output
// register behind the y * screen_width multiplier.
// Stepping state updates in the accept cycle, so advances may follow back to back.
// A stalled output holds both stages; inputs keep flowing while the output
// register can drain. rst_ni clears all control state and loads the reset config.
// The config port is always ready.
module line_pixel_stepper_unit import lps_pkg::*; #(
  parameter int unsigned COORD_BITS = 10
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // start_x, start_y, end_x, end_y, color, zero pad
  input  logic [((4*COORD_BITS+COLOR_W+7)/8)*8-1:0] s_axis_tdata,
  // operation
  input  logic                   s_axis_tuser,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // pixel_x, pixel_y, word_index, bit_shift, pixel_value, zero pad
  output logic [((2*COORD_BITS+WORD_INDEX_W+BIT_SHIFT_W+COLOR_W+7)/8)*8-1:0] m_axis_tdata,
  output logic                   m_axis_tlast,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i
);

  localparam int unsigned OUT_DATA_W =
    ((2*COORD_BITS+WORD_INDEX_W+BIT_SHIFT_W+COLOR_W+7)/8)*8;

  cfg_t                    cfg_q;
  logic                    pix_valid, pix_ready, pix_last;
  logic [COORD_BITS-1:0]   pix_x, pix_y;
  logic [COLOR_W-1:0]      pix_color;
  logic [COORD_BITS-1:0]   out_x, out_y;
  logic [WORD_INDEX_W-1:0] out_word;
  logic [BIT_SHIFT_W-1:0]  out_shift;
  logic [COLOR_W-1:0]      out_value;

  // config registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.screen_width <= SCREEN_WIDTH_RST;
      cfg_q.bpp_log2     <= BPP_LOG2_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_SCREEN_WIDTH: cfg_q.screen_width <= cfg_data_i[WIDTH_W-1:0];
        REG_BPP_LOG2:     cfg_q.bpp_log2     <= cfg_data_i[BPP_LOG2_W-1:0];
        default: ;
      endcase
    end
  end

  lps_stepper #(
    .COORD_BITS (COORD_BITS)
  ) u_stepper (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .op_i        (op_e'(s_axis_tuser)),
    .start_x_i   (s_axis_tdata[COORD_BITS-1:0]),
    .start_y_i   (s_axis_tdata[2*COORD_BITS-1:COORD_BITS]),
    .end_x_i     (s_axis_tdata[3*COORD_BITS-1:2*COORD_BITS]),
    .end_y_i     (s_axis_tdata[4*COORD_BITS-1:3*COORD_BITS]),
    .color_i     (s_axis_tdata[4*COORD_BITS+COLOR_W-1:4*COORD_BITS]),
    .pix_valid_o (pix_valid),
    .pix_ready_i (pix_ready),
    .pix_x_o     (pix_x),
    .pix_y_o     (pix_y),
    .pix_color_o (pix_color),
    .pix_last_o  (pix_last)
  );

  lps_addr #(
    .COORD_BITS (COORD_BITS)
  ) u_addr (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg_q),
    .pix_valid_i      (pix_valid),
    .pix_ready_o      (pix_ready),
    .pix_x_i          (pix_x),
    .pix_y_i          (pix_y),
    .pix_color_i      (pix_color),
    .pix_last_i       (pix_last),
    .out_valid_o      (m_axis_tvalid),
    .out_ready_i      (m_axis_tready),
    .out_x_o          (out_x),
    .out_y_o          (out_y),
    .out_word_index_o (out_word),
    .out_bit_shift_o  (out_shift),
    .out_value_o      (out_value),
    .out_last_o       (m_axis_tlast)
  );

  // pack result fields, pixel_x in the lowest bits, pixel_value highest
  assign m_axis_tdata = OUT_DATA_W'({out_value, out_shift, out_word, out_y, out_x});

endmodule

// ===== tb/tb_line_pixel_stepper_unit.sv =====
// Self-checking testbench for the line pixel stepper: random lines, stalls, config sweeps.
`timescale 1ns / 1ps

module tb_line_pixel_stepper_unit;
  import lps_pkg::*;

  localparam int COORD_W    = 10;
  localparam int IN_W       = ((4*COORD_W+COLOR_W+7)/8)*8;
  localparam int OUT_W      = ((2*COORD_W+WORD_INDEX_W+BIT_SHIFT_W+COLOR_W+7)/8)*8;
  localparam int COORD_MAX  = (1 << COORD_W) - 1;
  localparam int PHASE_ITEMS = 260;
  localparam int LONG_HOLD  = 400;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 8;

  typedef struct {
    op_e                op;
    logic [COORD_W-1:0] sx, sy, ex, ey;
    logic [COLOR_W-1:0] color;
  } line_cmd_t;

  typedef struct packed {
    logic [COORD_W-1:0]      px;
    logic [COORD_W-1:0]      py;
    logic [WORD_INDEX_W-1:0] word;
    logic [BIT_SHIFT_W-1:0]  shift;
    logic [COLOR_W-1:0]      value;
    logic                    is_end;
  } pixel_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [IN_W-1:0]  s_axis_tdata = '0;
  logic             s_axis_tuser = 1'b0;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [OUT_W-1:0] m_axis_tdata;
  logic             m_axis_tlast;
  logic                   cfg_valid_i = 1'b0;
  logic                   cfg_ready_o;
  logic [CFG_INDEX_W-1:0] cfg_index_i = REG_SCREEN_WIDTH;
  logic [CFG_DATA_W-1:0]  cfg_data_i = '0;

  line_pixel_stepper_unit i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #2 clk_i = ~clk_i;

  // Pending commands, the one on the bus, and expected pixels
  line_cmd_t cmd_q[$];
  line_cmd_t cmd_on_bus;
  pixel_t    pixel_q[$];
  bit        cmd_taken = 1'b0;
  int        mismatch_cnt = 0;
  int        cycle_cnt = 0;

  // Predictor copy of config and stepping state
  int unsigned        exp_width = 32'(SCREEN_WIDTH_RST);
  int unsigned        exp_bpp_log2 = 32'(BPP_LOG2_RST);
  logic [COORD_W-1:0] cur_x = '0, cur_y = '0, tgt_x = '0, tgt_y = '0;
  int                 dist_x = 0, dist_y = 0, err_acc = 0;
  bit                 x_neg = 1'b0, y_neg = 1'b0, line_active = 1'b0;
  logic [COLOR_W-1:0] line_color = '0;

  // Long receiver hold-off, requested by the stimulus
  int hold_left = 0;
  int holds_asked = 0;
  int holds_done = 0;

  // Walk one step of the error-term line and queue the pixel it produces
  task automatic step_line(input line_cmd_t c);
    pixel_t      p;
    int          prev;
    int unsigned pix_num, per_word;
    if (c.op == OP_START) begin
      cur_x  = c.sx;
      cur_y  = c.sy;
      tgt_x  = c.ex;
      tgt_y  = c.ey;
      dist_x = (c.ex > c.sx) ? int'(c.ex) - int'(c.sx) : int'(c.sx) - int'(c.ex);
      dist_y = (c.ey > c.sy) ? int'(c.ey) - int'(c.sy) : int'(c.sy) - int'(c.ey);
      x_neg  = !(c.sx < c.ex);
      y_neg  = !(c.sy < c.ey);
      err_acc = (dist_x > dist_y) ? dist_x / 2 : -(dist_y / 2);
      line_color = c.color;
    end else begin
      // advance with no line in progress is dropped
      if (!line_active) return;
      prev = err_acc;
      if (prev > -dist_x) begin
        err_acc -= dist_y;
        cur_x = x_neg ? cur_x - 1'b1 : cur_x + 1'b1;
      end
      if (prev < dist_y) begin
        err_acc += dist_x;
        cur_y = y_neg ? cur_y - 1'b1 : cur_y + 1'b1;
      end
    end
    pix_num  = int'(cur_x) + int'(cur_y) * exp_width;
    per_word = 32 >> exp_bpp_log2;
    p.px     = cur_x;
    p.py     = cur_y;
    p.word   = WORD_INDEX_W'(pix_num >> (5 - exp_bpp_log2));
    p.shift  = BIT_SHIFT_W'((pix_num & (per_word - 1)) << exp_bpp_log2);
    p.value  = line_color & COLOR_W'((1 << (1 << exp_bpp_log2)) - 1);
    p.is_end = (cur_x == tgt_x) && (cur_y == tgt_y);
    line_active = !p.is_end;
    pixel_q.push_back(p);
  endtask

  // Input acceptance, prediction and output checking
  always @(posedge clk_i) begin
    pixel_t got, want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = {m_axis_tdata[COORD_W-1:0], m_axis_tdata[2*COORD_W-1:COORD_W],
               m_axis_tdata[2*COORD_W+WORD_INDEX_W-1:2*COORD_W],
               m_axis_tdata[2*COORD_W+WORD_INDEX_W+BIT_SHIFT_W-1:2*COORD_W+WORD_INDEX_W],
               m_axis_tdata[2*COORD_W+WORD_INDEX_W+BIT_SHIFT_W+COLOR_W-1:
                            2*COORD_W+WORD_INDEX_W+BIT_SHIFT_W],
               m_axis_tlast};
        if (pixel_q.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("unexpected pixel x=%0d y=%0d", got.px, got.py);
        end else begin
          want = pixel_q.pop_front();
          if (got.px != want.px || got.py != want.py || got.word != want.word ||
              got.shift != want.shift || got.value != want.value ||
              got.is_end != want.is_end) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10) begin
              $display("pixel mismatch exp: x=%0d y=%0d word=%0h shift=%0d val=%0h last=%0b",
                       want.px, want.py, want.word, want.shift, want.value, want.is_end);
              $display("               got: x=%0d y=%0d word=%0h shift=%0d val=%0h last=%0b",
                       got.px, got.py, got.word, got.shift, got.value, got.is_end);
            end
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        step_line(cmd_on_bus);
        cmd_taken = 1'b1;
      end
    end
  end

  // Sender: bursts of items separated by random gaps
  int burst_left = 0;
  int gap_left = 0;
  always @(negedge clk_i) begin
    logic nxt_valid;
    nxt_valid = s_axis_tvalid && !cmd_taken;
    cmd_taken = 1'b0;
    if (!nxt_valid && rst_ni && cmd_q.size() > 0) begin
      if (gap_left > 0) begin
        gap_left--;
      end else begin
        cmd_on_bus = cmd_q.pop_front();
        nxt_valid = 1'b1;
        s_axis_tuser <= cmd_on_bus.op;
        s_axis_tdata <= {cmd_on_bus.color, cmd_on_bus.ey, cmd_on_bus.ex,
                         cmd_on_bus.sy, cmd_on_bus.sx};
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 30);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end
      end
    end
    s_axis_tvalid <= nxt_valid;
  end

  // Receiver: stall pattern in modes of random length, plus the long hold
  int rx_mode = 0;
  int mode_left = 0;
  always @(negedge clk_i) begin
    logic rdy;
    if (mode_left == 0) begin
      rx_mode = $urandom_range(0, 3);
      mode_left = $urandom_range(10, 120);
    end
    mode_left--;
    case (rx_mode)
      0:       rdy = 1'b1;
      1:       rdy = ($urandom_range(0, 1) == 1);
      2:       rdy = ($urandom_range(0, 3) == 0);
      default: rdy = (mode_left % 3 == 0);
    endcase
    m_axis_tready <= (hold_left > 0) ? 1'b0 : rdy;
  end

  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end else if (holds_done != holds_asked) begin
      hold_left <= LONG_HOLD;
      holds_done <= holds_done + 1;
    end
  end

  // Run limit
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("tb_line_pixel_stepper_unit: errors");
      $finish;
    end
  end

  function automatic line_cmd_t rand_cmd(input op_e op);
    line_cmd_t c;
    c.op    = op;
    c.sx    = COORD_W'($urandom);
    c.sy    = COORD_W'($urandom);
    c.ex    = COORD_W'($urandom);
    c.ey    = COORD_W'($urandom);
    c.color = COLOR_W'($urandom);
    return c;
  endfunction

  function automatic logic [COORD_W-1:0] pick_coord();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return COORD_W'(COORD_MAX);
      default: return COORD_W'($urandom);
    endcase
  endfunction

  function automatic logic [COORD_W-1:0] near_coord(input logic [COORD_W-1:0] base,
                                                    input int span);
    int lo, hi;
    lo = (int'(base) > span) ? int'(base) - span : 0;
    hi = (int'(base) + span > COORD_MAX) ? COORD_MAX : int'(base) + span;
    return COORD_W'($urandom_range(hi, lo));
  endfunction

  task automatic push_cmd(input op_e op, input int sx, input int sy, input int ex,
                          input int ey, input int color);
    line_cmd_t c;
    c = rand_cmd(op);
    if (op == OP_START) begin
      c.sx = COORD_W'(sx);
      c.sy = COORD_W'(sy);
      c.ex = COORD_W'(ex);
      c.ey = COORD_W'(ey);
      c.color = COLOR_W'(color);
    end
    cmd_q.push_back(c);
  endtask

  // Random lines: mostly run to the end, some with idle advances after it,
  // some abandoned by the next start
  task automatic queue_lines(input int budget);
    line_cmd_t c;
    int queued, span, steps, dy_len, n_adv, pick;
    queued = 0;
    while (queued < budget) begin
      c = rand_cmd(OP_START);
      pick = $urandom_range(0, 29);
      span = (pick == 0) ? COORD_MAX : (pick < 8) ? 2 : 16;
      c.sx = pick_coord();
      c.sy = pick_coord();
      c.ex = near_coord(c.sx, span);
      c.ey = near_coord(c.sy, span);
      steps = (c.ex > c.sx) ? int'(c.ex) - int'(c.sx) : int'(c.sx) - int'(c.ex);
      dy_len = (c.ey > c.sy) ? int'(c.ey) - int'(c.sy) : int'(c.sy) - int'(c.ey);
      if (dy_len > steps)
        steps = dy_len;
      pick = $urandom_range(0, 9);
      if (pick < 6)      n_adv = steps;
      else if (pick < 8) n_adv = steps + $urandom_range(1, 3);
      else               n_adv = $urandom_range(0, steps);
      if (n_adv > 120) n_adv = 120;
      cmd_q.push_back(c);
      queued++;
      for (int k = 0; k < n_adv; k++) begin
        cmd_q.push_back(rand_cmd(OP_ADVANCE));
        if (k < steps) queued++;
      end
    end
  endtask

  // Block until nothing is pending, then let trailing work settle
  task automatic wait_idle();
    do @(posedge clk_i);
    while (cmd_q.size() != 0 || s_axis_tvalid || pixel_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input int unsigned val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= CFG_DATA_W'(val);
    do @(posedge clk_i);
    while (!cfg_ready_o);
    if (idx == REG_SCREEN_WIDTH) exp_width = val & 32'h7FF;
    else                         exp_bpp_log2 = val & 32'h3;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Screen width / bpp settings for the later phases
  int unsigned width_set[6] = '{1, 1024, 2047, 0, 640, 0};
  int unsigned bpp_set[6]   = '{3, 1, 2, 0, 3, 0};

  initial begin
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: idle advance, single point, extremes, abandon, axis-aligned lines
    push_cmd(OP_ADVANCE, 0, 0, 0, 0, 0);
    push_cmd(OP_START, 0, 0, 0, 0, 255);
    push_cmd(OP_ADVANCE, 0, 0, 0, 0, 0);
    push_cmd(OP_START, COORD_MAX, COORD_MAX, COORD_MAX - 3, COORD_MAX - 2, 8'hAA);
    repeat (3) push_cmd(OP_ADVANCE, 0, 0, 0, 0, 0);
    push_cmd(OP_START, COORD_MAX, 0, 0, COORD_MAX, 0);
    repeat (2) push_cmd(OP_ADVANCE, 0, 0, 0, 0, 0);
    push_cmd(OP_START, 5, 5, 8, 3, 8'h55);
    repeat (4) push_cmd(OP_ADVANCE, 0, 0, 0, 0, 0);
    push_cmd(OP_START, 3, 7, 3, 4, 8'h0F);
    repeat (3) push_cmd(OP_ADVANCE, 0, 0, 0, 0, 0);
    push_cmd(OP_START, 10, 2, 6, 2, 8'hF0);
    repeat (4) push_cmd(OP_ADVANCE, 0, 0, 0, 0, 0);
    queue_lines(PHASE_ITEMS);
    wait_idle();

    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 5) begin
        width_set[ph] = $urandom_range(1, 1024);
        bpp_set[ph] = $urandom_range(0, 3);
      end
      write_reg(REG_SCREEN_WIDTH, width_set[ph]);
      write_reg(REG_BPP_LOG2, bpp_set[ph]);
      queue_lines(PHASE_ITEMS);
      // receiver holds off while the sender keeps offering
      if (ph == 1 || ph == 4) holds_asked++;
      wait_idle();
    end

    repeat (10) @(posedge clk_i);
    if (pixel_q.size() != 0) mismatch_cnt++;
    if (mismatch_cnt == 0)
      $display("tb_line_pixel_stepper_unit: clean");
    else
      $display("tb_line_pixel_stepper_unit: errors");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+src
src/lps_pkg.sv
src/lps_stepper.sv
src/lps_addr.sv
src/line_pixel_stepper_unit.sv
tb/tb_line_pixel_stepper_unit.sv
